// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Every check is clocked on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication check.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cbas_pkg.sv -----
package cbas_pkg;

  localparam int unsigned DeltaW     = 10;
  localparam int unsigned ValueW     = 16;
  localparam int unsigned DelayW     = 12;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned LineTimerW = 13;
  localparam int unsigned WorkTimerW = 22;

  // Time the voltage must stay on one side of the stop threshold.
  localparam logic [LineTimerW-1:0] LineQualifyMs = 13'd5000;
  localparam logic [WorkTimerW-1:0] MsPerSecond   = 22'd1000;

  typedef logic [DeltaW-1:0]     delta_t;
  typedef logic [ValueW-1:0]     value_t;
  typedef logic [CfgIndexW-1:0]  cfg_index_t;
  typedef logic [LineTimerW-1:0] line_timer_t;
  typedef logic [WorkTimerW-1:0] work_timer_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_CUT_OFF = 2'd1,
    CMD_BYPASS  = 2'd2,
    CMD_WORK    = 2'd3
  } cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_STOP_VOLTAGE      = 3'd0,
    CFG_UNDER_VOLTAGE     = 3'd1,
    CFG_HIGH_VOLTAGE      = 3'd2,
    CFG_OVERCURRENT_LIMIT = 3'd3,
    CFG_WORK_DELAY        = 3'd4
  } cfg_idx_e;

  // Live settings as seen by the decision logic. The work delay is kept
  // already scaled to milliseconds.
  typedef struct packed {
    value_t      stop_voltage;
    value_t      under_voltage;
    value_t      high_voltage;
    value_t      overcurrent_limit;
    work_timer_t work_target;
  } cfg_t;

endpackage

// ----- hdl/cbas_intf.sv -----
interface cbas_in_if import cbas_pkg::*; ();
  logic   valid;
  logic   ready;
  delta_t elapsed_ms;
  value_t line_voltage;
  value_t peak_current;
  logic   serious_fault;
  logic   minor_fault;

  modport source (output valid, elapsed_ms, line_voltage, peak_current, serious_fault,
                  minor_fault, input ready);
  modport sink   (input valid, elapsed_ms, line_voltage, peak_current, serious_fault,
                  minor_fault, output ready);
endinterface

interface cbas_out_if import cbas_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       line_running;

  modport source (output valid, command, line_running, input ready);
  modport sink   (input valid, command, line_running, output ready);
endinterface

interface cbas_cfg_if import cbas_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  value_t     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/cbas_cfg_regs.sv -----
module cbas_cfg_regs import cbas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbas_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic [DelayW-1:0] delay_s;

  assign cfg_i.ready = 1'b1;
  assign delay_s     = cfg_i.data[DelayW-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_STOP_VOLTAGE:      cfg_d.stop_voltage      = cfg_i.data;
        CFG_UNDER_VOLTAGE:     cfg_d.under_voltage     = cfg_i.data;
        CFG_HIGH_VOLTAGE:      cfg_d.high_voltage      = cfg_i.data;
        CFG_OVERCURRENT_LIMIT: cfg_d.overcurrent_limit = cfg_i.data;
        // Scaled to milliseconds once here, so the tick path only compares.
        CFG_WORK_DELAY:        cfg_d.work_target = WorkTimerW'(delay_s) * MsPerSecond;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_voltage      <= '0;
      cfg_q.under_voltage     <= '0;
      cfg_q.high_voltage      <= '1;
      cfg_q.overcurrent_limit <= '1;
      cfg_q.work_target       <= 22'd10000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/capacitor_bank_auto_switch_unit.sv -----
// Channel  | Dir | Payload                                              | Beat
// ---------+-----+------------------------------------------------------+----------------------
// in_i     | in  | elapsed_ms, line_voltage, peak_current, 2 fault flags | one poll tick
// out_o    | out | command, line_running                                | one result per tick
// cfg_i    | in  | index, data                                          | one register write
//
// A tick passes from the input register into the result register, and a new
// tick is taken every cycle while the result is not stalled.
// The line and work timers update as a tick moves into the result register, so
// each tick sees the state its predecessor left. Reset clears the timers, marks
// the line stopped and loads the register reset values. A stalled result holds
// both stages; ready falls only when both stages are full.
module capacitor_bank_auto_switch_unit import cbas_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbas_in_if.sink     in_i,
  cbas_out_if.source  out_o,
  cbas_cfg_if.sink    cfg_i
);

  cfg_t cfg;

  cbas_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register stage.
  logic   in_valid_q;
  delta_t delta_q;
  value_t volt_q;
  value_t cur_q;
  logic   serious_q;
  logic   minor_q;

  // Result register stage.
  logic   out_valid_q;
  cmd_e   cmd_q, cmd_d;
  logic   running_q, running_d;

  // Line and work state.
  line_timer_t run_timer_q, run_timer_d;
  line_timer_t stop_timer_q, stop_timer_d;
  work_timer_t work_timer_q, work_timer_d;

  logic advance;
  logic in_fire;

  // The tick in the input register moves on whenever the result slot is free
  // or is being emptied this cycle.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  // Duration timers: add the elapsed time while the condition holds, saturate
  // at the target, fire once the target is reached, clear when it drops on an evaluated tick.
  logic [LineTimerW:0] run_sum, stop_sum;
  logic [WorkTimerW:0] work_sum;
  line_timer_t         run_sat, stop_sat;
  work_timer_t         work_sat;
  logic                run_cond, stop_cond, run_fire, stop_fire;
  logic                work_ok, work_eval, work_fire;

  always_comb begin
    run_cond  = volt_q > cfg.stop_voltage;
    stop_cond = volt_q < cfg.stop_voltage;

    run_sum  = {1'b0, run_timer_q} + (LineTimerW + 1)'(delta_q);
    run_sat  = (run_sum > {1'b0, LineQualifyMs}) ? LineQualifyMs : run_sum[LineTimerW-1:0];
    run_fire = run_cond && (run_sat >= LineQualifyMs);
    run_timer_d = run_cond ? run_sat : '0;

    stop_sum  = {1'b0, stop_timer_q} + (LineTimerW + 1)'(delta_q);
    stop_sat  = (stop_sum > {1'b0, LineQualifyMs}) ? LineQualifyMs
                                                    : stop_sum[LineTimerW-1:0];
    // The stop test is only looked at when the running test did not fire.
    stop_fire = !run_fire && stop_cond && (stop_sat >= LineQualifyMs);
    if (run_fire) begin
      stop_timer_d = stop_timer_q;
    end else begin
      stop_timer_d = stop_cond ? stop_sat : '0;
    end

    if (run_fire) begin
      running_d = 1'b1;
    end else if (stop_fire) begin
      running_d = 1'b0;
    end else begin
      running_d = running_q;
    end

    // The work condition is a strict band on voltage and a strict limit on
    // current; its timer only advances on fault-free running ticks.
    work_ok   = (volt_q > cfg.under_voltage) && (volt_q < cfg.high_voltage) &&
                (cur_q < cfg.overcurrent_limit);
    work_eval = running_d && !serious_q && !minor_q;
    work_sum  = {1'b0, work_timer_q} + (WorkTimerW + 1)'(delta_q);
    work_sat  = (work_sum > {1'b0, cfg.work_target}) ? cfg.work_target
                                                      : work_sum[WorkTimerW-1:0];
    work_fire = work_eval && work_ok && (work_sat >= cfg.work_target);
    if (work_eval) begin
      work_timer_d = work_ok ? work_sat : '0;
    end else begin
      work_timer_d = work_timer_q;
    end

    // A stopped line always gets cut-off; a serious fault outranks a minor one.
    if (!running_d) begin
      cmd_d = CMD_CUT_OFF;
    end else if (serious_q) begin
      cmd_d = CMD_CUT_OFF;
    end else if (minor_q) begin
      cmd_d = CMD_BYPASS;
    end else if (work_fire) begin
      cmd_d = CMD_WORK;
    end else begin
      cmd_d = CMD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      running_q    <= 1'b0;
      run_timer_q  <= '0;
      stop_timer_q <= '0;
      work_timer_q <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        running_q    <= running_d;
        run_timer_q  <= run_timer_d;
        stop_timer_q <= stop_timer_d;
        work_timer_q <= work_timer_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      delta_q   <= in_i.elapsed_ms;
      volt_q    <= in_i.line_voltage;
      cur_q     <= in_i.peak_current;
      serious_q <= in_i.serious_fault;
      minor_q   <= in_i.minor_fault;
    end
    if (advance) begin
      cmd_q <= cmd_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.command      = cmd_q;
  assign out_o.line_running = running_q;

`include "assert_macros.svh"

  `ASSERT_PROP(a_line_timers_bounded,
               (run_timer_q <= LineQualifyMs) && (stop_timer_q <= LineQualifyMs),
               "line qualification timer ran past its target")
  `ASSERT_IMPLIES(a_stopped_means_cut_off, out_valid_q && !running_q,
                  cmd_q == CMD_CUT_OFF, "stopped line did not command cut-off")
  `ASSERT_PROP(a_advance_fills_result, advance |=> out_valid_q,
               "tick moved on but no result was presented")

endmodule
